// ----- hw/rtl/loss_and_gradient_unit_core_assert.svh -----
// Assertion macros for the loss and gradient unit.
// Used by loss_and_gradient_unit_core.sv; needs no other file.
`ifndef LOSS_AND_GRADIENT_UNIT_CORE_ASSERT_SVH
`define LOSS_AND_GRADIENT_UNIT_CORE_ASSERT_SVH
// Assert a property on the rising clock edge, with reset as disable.
`define LGU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Assert a property that must hold during reset as well.
`define LGU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

// ----- hw/rtl/lgu_pkg.sv -----
// Package for the loss and gradient unit: payload types, constants, log2 table.
// Used by loss_and_gradient_unit_core.sv; depends on nothing.
package lgu_pkg;
    localparam int MaxItems = 65536;
    localparam int LogTableBits = 8;
    localparam int CntW = $clog2(MaxItems + 1);
    localparam logic [31:0] Ln2Q32 = 32'd2977044472;
    localparam logic signed [47:0] ValMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] ValMin = 48'sh8000_0000_0000;
    localparam logic [0:0] KindBce = 1'b0;
    localparam logic [0:0] KindMse = 1'b1;
    localparam logic [0:0] RegLossKind = 1'b0;
    localparam logic [0:0] RegEpsTerm = 1'b1;

    typedef struct packed {
        logic signed [31:0] label;
        logic signed [31:0] prediction;
        logic               last_item;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic signed [47:0] value;
        logic               last;
    } t_out;

    // log2(1 + i/2^B) in Q0.20, truncated, by repeated squaring
    function automatic logic [19:0] log2_frac(input logic [LogTableBits-1:0] i);
        logic [63:0] y;
        logic [19:0] f;
        y = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
        f = '0;
        for (int b = 0; b < 20; b++) begin
            y = (y * y) >> 30;
            f = {f[18:0], 1'b0};
            if (y >= (64'd1 << 31)) begin
                f[0] = 1'b1;
                y = y >> 1;
            end
        end
        return f;
    endfunction

    typedef logic [19:0] t_log_rom [2**LogTableBits];

    function automatic t_log_rom build_rom();
        t_log_rom r;
        for (int i = 0; i < 2**LogTableBits; i++) begin
            r[i] = log2_frac(LogTableBits'(i));
        end
        return r;
    endfunction

    localparam t_log_rom LogRom = build_rom();
endpackage

// ----- hw/rtl/loss_and_gradient_unit_core.sv -----
// Loss and gradient unit top level: sequencer, shared multiplier, shared divider.
// Depends on lgu_pkg.sv and loss_and_gradient_unit_core_assert.svh.
//
// Usage:
//  - Input channel i_in_valid / o_in_stall carries one label and prediction
//    pair (signed Q15.16) plus last_item. One transaction per element.
//  - Output channel o_out_valid / i_out_stall carries results: one gradient
//    per element, then on a last element also the mean loss (kind 1).
//  - Config: i_cfg_we, i_cfg_idx, i_cfg_data; index 0 loss_kind, 1 eps_term.
//    Write only while the unit is idle.
//  - A BCE gradient follows five products on the shared 32x32 multiplier
//    and then a 64-step radix-2 divide; an MSE gradient follows a single
//    product. A last element then runs a second divide for its mean loss.
//    The radix-2 divider produces one quotient bit a cycle.
//  - One element is in work at a time; o_in_stall is high meanwhile.
//  - A held result waits in the output register while the receiver stalls;
//    the sequencer pauses until it is taken.
//  - Synchronous active-low reset clears sum, count and control; sets loss_kind 0, eps_term 1.
`include "loss_and_gradient_unit_core_assert.svh"
module loss_and_gradient_unit_core
    import lgu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MWAIT, S_DIV, S_GRAD, S_ACC, S_MEAN, S_MDIV, S_MOUT, S_WAIT
    } t_state;

    t_state r_state;
    logic   r_kind;
    logic [15:0] r_eps;
    logic [63:0] r_sum;
    logic [CntW-1:0] r_cnt;
    // latched operands
    logic signed [32:0] r_t, r_p;
    logic r_lst, r_neg;
    logic [2:0] r_step;
    logic [63:0] r_a;      // work register: den
    logic [63:0] r_acc;    // element loss accumulator
    // shared multiplier
    logic [31:0] r_ma, r_mb;
    logic [63:0] r_mp;
    // divider
    logic [63:0] r_dq, r_dr, r_dd;
    logic [6:0]  r_dn;
    logic        r_vld;
    t_out        r_out;

    // element operand helpers
    logic signed [32:0] lab_c, pre_c, t_c, p_c;
    always_comb begin
        lab_c = 33'(i_in.label);
        pre_c = 33'(i_in.prediction);
        t_c = lab_c < 0 ? 33'sd0 : (lab_c > 33'sd65536 ? 33'sd65536 : lab_c);
        p_c = pre_c < 1 ? 33'sd1 : (pre_c > 33'sd65535 ? 33'sd65535 : pre_c);
    end

    // neg-log of a 16-bit value (sequenced through the multiplier)
    function automatic logic [31:0] nlog2(input logic [15:0] x);
        int k;
        logic [15:0] m;
        logic [31:0] r;
        k = 0;
        for (int j = 0; j < 16; j++) if (x[j]) k = j;
        m = 16'((x << (15 - k)) & 16'h7FFF);
        r = (32'(16 - k) << 20) - 32'(LogRom[m[14:15-LogTableBits]]);
        return r;
    endfunction

    logic [64:0] trial;
    always_comb begin
        trial = {r_dr, r_dq[63]} - {1'b0, r_dd};
    end

    logic [47:0] mean_q;
    assign mean_q = r_dq > 64'(ValMax) ? 48'(ValMax) : r_dq[47:0];

    // output register takes a new result this cycle
    logic out_load;
    assign out_load = (!r_vld || !i_out_stall)
                      && (r_state == S_GRAD || (r_state == S_MDIV && r_dn == 7'd0));

    always_ff @(posedge i_clk) begin
        r_mp <= 64'(r_ma) * 64'(r_mb);
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_kind <= 1'b0; r_eps <= 16'd1;
            r_sum <= '0; r_cnt <= '0; r_vld <= 1'b0; r_dn <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    RegLossKind: r_kind <= i_cfg_data[0];
                    RegEpsTerm:  r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_vld && !i_out_stall && !out_load) r_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_lst <= i_in.last_item;
                    r_step <= '0; r_acc <= '0;
                    if (r_kind == KindBce) begin
                        r_t <= t_c; r_p <= p_c;
                        r_neg <= p_c < t_c;
                        r_ma <= 32'(p_c); r_mb <= 32'(33'sd65536 - p_c);
                        r_state <= S_MWAIT;
                    end else begin
                        r_t <= lab_c; r_p <= pre_c;
                        r_ma <= 32'(lab_c > pre_c ? lab_c - pre_c : pre_c - lab_c);
                        r_mb <= 32'(lab_c > pre_c ? lab_c - pre_c : pre_c - lab_c);
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: r_state <= S_MUL;
                S_MUL: begin
                    if (r_kind == KindMse) begin
                        r_acc <= (r_mp + 64'd32768) >> 16;
                        r_state <= S_GRAD;
                    end else begin
                        r_step <= r_step + 3'd1;
                        r_state <= S_MWAIT;
                        unique case (r_step)
                            3'd0: begin   // den = p(1-p) + eps<<16
                                r_a <= r_mp + (64'(r_eps == 0 ? 16'd1 : r_eps) << 16);
                                r_ma <= nlog2(16'(r_p)); r_mb <= Ln2Q32;
                            end
                            3'd1: begin
                                r_ma <= 32'((r_mp + 64'h8000_0000) >> 32);
                                r_mb <= 32'(r_t);
                            end
                            3'd2: begin
                                r_acc <= r_mp;
                                r_ma <= nlog2(16'(33'sd65536 - r_p)); r_mb <= Ln2Q32;
                            end
                            3'd3: begin
                                r_ma <= 32'((r_mp + 64'h8000_0000) >> 32);
                                r_mb <= 32'(33'sd65536 - r_t);
                            end
                            default: begin
                                r_acc <= (r_acc + r_mp + 64'(1 << 19)) >> 20;
                                // dividend (mag<<32) + den/2 ; start divide
                                r_dq <= (64'(r_neg ? r_t - r_p : r_p - r_t) << 32)
                                        + (r_a >> 1);
                                r_dr <= '0; r_dd <= r_a; r_dn <= 7'd64;
                                r_state <= S_DIV;
                            end
                        endcase
                    end
                end
                S_DIV, S_MDIV: begin
                    if (r_dn != 0) begin
                        if (!trial[64]) begin
                            r_dr <= trial[63:0]; r_dq <= {r_dq[62:0], 1'b1};
                        end else begin
                            r_dr <= {r_dr[62:0], r_dq[63]}; r_dq <= {r_dq[62:0], 1'b0};
                        end
                        r_dn <= r_dn - 7'd1;
                    end else if (r_state == S_DIV) begin
                        r_state <= S_GRAD;
                    end else if (!r_vld || !i_out_stall) begin
                        r_out.kind <= 1'b1;
                        r_out.value <= (r_dr << 1) >= r_dd ? ((r_dq + 1) > 64'(ValMax)
                                       ? ValMax : 48'(r_dq + 1)) : mean_q;
                        r_out.last <= 1'b1; r_vld <= 1'b1;
                        r_sum <= '0; r_cnt <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_GRAD: if (!r_vld || !i_out_stall) begin
                    r_out.kind <= 1'b0;
                    if (r_kind == KindMse) begin
                        r_out.value <= 48'(34'(r_p - r_t) <<< 1);
                    end else begin
                        r_out.value <= r_neg ? -48'(r_dq[46:0]) : 48'(r_dq[46:0]);
                    end
                    r_out.last <= !r_lst; r_vld <= 1'b1;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_cnt != CntW'(MaxItems)) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_sum <= (r_sum > ~r_acc) ? '1 : r_sum + r_acc;
                    end
                    r_state <= r_lst ? S_MEAN : S_WAIT;
                end
                S_WAIT: r_state <= S_IDLE;
                S_MEAN: begin
                    r_dq <= r_sum; r_dr <= '0; r_dn <= 7'd64;
                    r_dd <= r_cnt == 0 ? 64'd1 : 64'(r_cnt);
                    r_state <= S_MDIV;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_vld;
    assign o_out = r_out;

    `LGU_ASSERT(a_cnt_max, r_cnt <= CntW'(MaxItems), "count beyond max")
    `LGU_ASSERT(a_div_cnt, r_dn <= 7'd64, "divide count out of range")
    `LGU_ASSERT(a_mean_last, (o_out_valid && o_out.kind) |-> o_out.last, "mean not last")
endmodule
